FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps

package i2cm_pkg;

	localparam int MAX_READ_BYTES = 16;
	localparam logic [4:0] MAX_WRITE_BYTES = 5'd2;

	typedef struct packed {
		logic        kind;
		logic [7:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic        is_read;
		logic [4:0]  byte_count;
		logic [15:0] write_data;
		logic        sda_sample;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_release;
		logic       busy_res;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       last_byte;
		logic       start_error;
		logic       nack_error;
		logic       done_res;
	} result_t;

	typedef struct packed {
		logic        is_req;
		logic [7:0]  dev_addr;
		logic [7:0]  reg_addr;
		logic        is_read;
		logic [4:0]  count;
		logic [15:0] write_data;
		logic        sda_sample;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef enum logic [13:0] {
		PH_IDLE   = 14'b00000000000001,
		PH_START  = 14'b00000000000010,
		PH_ADDRW  = 14'b00000000000100,
		PH_ACK1   = 14'b00000000001000,
		PH_REG    = 14'b00000000010000,
		PH_ACK2   = 14'b00000000100000,
		PH_DATA   = 14'b00000001000000,
		PH_ACK3   = 14'b00000010000000,
		PH_RSTART = 14'b00000100000000,
		PH_ADDRR  = 14'b00001000000000,
		PH_ACK4   = 14'b00010000000000,
		PH_RECV   = 14'b00100000000000,
		PH_MACK   = 14'b01000000000000,
		PH_STOP   = 14'b10000000000000
	} phase_t;

endpackage

FILE: sv/i2cm_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
`timescale 1ns / 1ps

module i2cm_front import i2cm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  item_t     item,
	output cmd_head_t head,
	input  logic      pop
);

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cmd_t       cmd;
	logic [4:0] cnt;

	always_comb begin
		cnt = item.byte_count;
		if (item.is_read) begin
			if (cnt == 5'd0) begin
				cnt = 5'd1;
			end else if (cnt > 5'(MAX_READ_BYTES)) begin
				cnt = 5'(MAX_READ_BYTES);
			end
		end else if (cnt > MAX_WRITE_BYTES) begin
			cnt = MAX_WRITE_BYTES;
		end
		cmd.is_req     = item.kind;
		cmd.dev_addr   = item.dev_addr;
		cmd.reg_addr   = item.reg_addr;
		cmd.is_read    = item.is_read;
		cmd.count      = cnt;
		cmd.write_data = item.write_data;
		cmd.sda_sample = item.sda_sample;
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: sv/i2cm_back.sv
// Back end: bus sequencer that runs one step per queued item, with a result register.
`timescale 1ns / 1ps

module i2cm_back import i2cm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_head_t head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output result_t   result
);

	phase_t      ph_q, ph_n;
	logic [1:0]  step_q, step_n;
	logic [3:0]  bc_q, bc_n;
	logic [7:0]  sh_q, sh_n;
	logic [4:0]  bl_q, bl_n;
	logic [7:0]  dev_q, dev_n;
	logic [7:0]  rega_q, rega_n;
	logic        rd_q, rd_n;
	logic [15:0] data_q, data_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	logic [1:0]  err_q, err_n;
	logic        fin;
	logic        done;
	logic        rv;
	logic [7:0]  rb;
	logic        rl;
	logic        smp;
	result_t     res_q;
	logic        res_valid_q;

	assign pop = head.valid && (!res_valid_q || !result_stall);
	assign smp = head.cmd.sda_sample;

	always_comb begin
		ph_n   = ph_q;
		step_n = step_q;
		bc_n   = bc_q;
		sh_n   = sh_q;
		bl_n   = bl_q;
		dev_n  = dev_q;
		rega_n = rega_q;
		rd_n   = rd_q;
		data_n = data_q;
		scl_n  = scl_q;
		sda_n  = sda_q;
		err_n  = err_q;
		fin    = 1'b0;
		done   = 1'b0;
		rv     = 1'b0;
		rb     = 8'd0;
		rl     = 1'b0;
		if (head.cmd.is_req) begin
			if (ph_q == PH_IDLE) begin
				dev_n  = head.cmd.dev_addr;
				rega_n = head.cmd.reg_addr;
				rd_n   = head.cmd.is_read;
				data_n = head.cmd.write_data;
				bl_n   = head.cmd.count;
				err_n  = 2'b00;
				ph_n   = PH_START;
				step_n = 2'd0;
				bc_n   = 4'd0;
				sh_n   = 8'd0;
			end
		end else begin
			unique case (ph_q)
				PH_START, PH_RSTART: begin
					if (step_q == 2'd0) begin
						sda_n = 1'b1;
						scl_n = 1'b1;
						if (!smp) begin
							err_n[0] = 1'b1;
							fin = 1'b1;
						end else begin
							step_n = 2'd1;
						end
					end else if (step_q == 2'd1) begin
						sda_n = 1'b0;
						if (smp) begin
							err_n[0] = 1'b1;
							fin = 1'b1;
						end else begin
							step_n = 2'd2;
						end
					end else begin
						sda_n = 1'b0;
						fin = 1'b1;
					end
				end
				PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
					if (bc_q[3]) begin
						scl_n = 1'b0;
						fin = 1'b1;
					end else if (step_q == 2'd0) begin
						scl_n = 1'b0;
						step_n = 2'd1;
					end else if (step_q == 2'd1) begin
						sda_n = sh_q[7];
						sh_n = {sh_q[6:0], 1'b0};
						step_n = 2'd2;
					end else begin
						scl_n = 1'b1;
						bc_n = bc_q + 4'd1;
						step_n = 2'd0;
					end
				end
				PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
					if (step_q == 2'd0) begin
						scl_n = 1'b0;
						step_n = 2'd1;
					end else if (step_q == 2'd1) begin
						sda_n = 1'b1;
						step_n = 2'd2;
					end else if (step_q == 2'd2) begin
						scl_n = 1'b1;
						if (smp) begin
							err_n[1] = 1'b1;
						end
						step_n = 2'd3;
					end else begin
						scl_n = 1'b0;
						fin = 1'b1;
					end
				end
				PH_RECV: begin
					if (step_q == 2'd0) begin
						sda_n = 1'b1;
						step_n = 2'd1;
					end else if (step_q == 2'd1) begin
						scl_n = 1'b0;
						step_n = 2'd2;
					end else if (step_q == 2'd2) begin
						scl_n = 1'b1;
						sh_n = {sh_q[6:0], smp};
						bc_n = bc_q + 4'd1;
						step_n = bc_n[3] ? 2'd3 : 2'd1;
					end else begin
						scl_n = 1'b0;
						rv = 1'b1;
						rb = sh_q;
						rl = (bl_q <= 5'd1);
						fin = 1'b1;
					end
				end
				PH_MACK: begin
					if (step_q == 2'd0) begin
						scl_n = 1'b0;
						step_n = 2'd1;
					end else if (step_q == 2'd1) begin
						sda_n = !(bl_q > 5'd1);
						step_n = 2'd2;
					end else if (step_q == 2'd2) begin
						scl_n = 1'b1;
						step_n = 2'd3;
					end else begin
						scl_n = 1'b0;
						fin = 1'b1;
					end
				end
				PH_STOP: begin
					if (step_q == 2'd0) begin
						scl_n = 1'b0;
						step_n = 2'd1;
					end else if (step_q == 2'd1) begin
						sda_n = 1'b0;
						step_n = 2'd2;
					end else if (step_q == 2'd2) begin
						scl_n = 1'b1;
						step_n = 2'd3;
					end else begin
						sda_n = 1'b1;
						done = 1'b1;
						ph_n = PH_IDLE;
						step_n = 2'd0;
						bc_n = 4'd0;
						sh_n = 8'd0;
					end
				end
				default: begin
				end
			endcase

			if (fin) begin
				step_n = 2'd0;
				bc_n   = 4'd0;
				sh_n   = 8'd0;
				unique case (ph_q)
					PH_START: begin
						ph_n = PH_ADDRW;
						sh_n = dev_q;
					end
					PH_ADDRW: ph_n = PH_ACK1;
					PH_ACK1: begin
						ph_n = PH_REG;
						sh_n = rega_q;
					end
					PH_REG:   ph_n = PH_ACK2;
					PH_ACK2, PH_ACK3: begin
						if (ph_q == PH_ACK2 && rd_q) begin
							ph_n = PH_RSTART;
						end else if (bl_q != 5'd0) begin
							sh_n = (bl_q == 5'd2) ? data_q[15:8] : data_q[7:0];
							bl_n = bl_q - 5'd1;
							ph_n = PH_DATA;
						end else begin
							ph_n = PH_STOP;
						end
					end
					PH_DATA:  ph_n = PH_ACK3;
					PH_RSTART: begin
						ph_n = PH_ADDRR;
						sh_n = dev_q + 8'd1;
					end
					PH_ADDRR: ph_n = PH_ACK4;
					PH_ACK4:  ph_n = PH_RECV;
					PH_RECV:  ph_n = PH_MACK;
					PH_MACK: begin
						if (bl_q > 5'd1) begin
							bl_n = bl_q - 5'd1;
							ph_n = PH_RECV;
						end else begin
							bl_n = 5'd0;
							ph_n = PH_STOP;
						end
					end
					default:  ph_n = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			step_q      <= 2'd0;
			bc_q        <= 4'd0;
			sh_q        <= 8'd0;
			bl_q        <= 5'd0;
			dev_q       <= 8'd0;
			rega_q      <= 8'd0;
			rd_q        <= 1'b0;
			data_q      <= 16'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			err_q       <= 2'b00;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				ph_q        <= ph_n;
				step_q      <= step_n;
				bc_q        <= bc_n;
				sh_q        <= sh_n;
				bl_q        <= bl_n;
				dev_q       <= dev_n;
				rega_q      <= rega_n;
				rd_q        <= rd_n;
				data_q      <= data_n;
				scl_q       <= scl_n;
				sda_q       <= sda_n;
				err_q       <= err_n;
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q.scl_level   <= scl_n;
			res_q.sda_release <= sda_n;
			res_q.busy_res    <= (ph_n != PH_IDLE) || done;
			res_q.read_valid  <= rv;
			res_q.read_byte   <= rb;
			res_q.last_byte   <= rl;
			res_q.start_error <= err_n[0];
			res_q.nack_error  <= err_n[1];
			res_q.done_res    <= done;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

FILE: sv/i2c_master_register_access.sv
// Top level of the I2C register access master.
// The item channel carries requests and delay ticks: kind set starts a register
// transaction when the sequencer is idle (ignored otherwise), kind clear is one
// bus delay step that also carries the sampled SDA level.
// Every accepted item yields exactly one transaction on the result channel with
// the SCL and SDA drive levels for that step, the busy and done flags, the sticky
// start and acknowledge error flags, and any received read byte.
// Items enter a two-entry queue; the sequencer takes one item per cycle from it
// while the result side does not stall, and registers the result, so an accepted
// item passes through the queue and then the result register. Sustained rate is
// one item per cycle when nothing stalls, set by the single-step sequencer.
// When the result side stalls, the result register holds and the sequencer stops;
// the queue keeps taking items until both entries are full, then raises stall.
// Reset empties the queue and the result register, leaves the sequencer idle
// with both bus lines released high and the error flags clear.
`timescale 1ns / 1ps

module i2c_master_register_access import i2cm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	cmd_head_t head;
	logic      pop;

	i2cm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.head       (head),
		.pop        (pop)
	);

	i2cm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

FILE: sv/i2cm_checker.sv
// Port-level checks for the I2C register access master and their binding.
`timescale 1ns / 1ps

module i2cm_checker import i2cm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("item changed while stalled");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> result.busy_res)
		else $error("done without busy");

	a_done_pins: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> result.scl_level && result.sda_release)
		else $error("stop did not release both lines");

	a_read_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.read_valid |-> result.read_byte == 8'd0 && !result.last_byte)
		else $error("read fields set without a read byte");

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (.*);

FILE: tb/i2c_master_register_access_tb.sv
// Self-checking testbench for the I2C register access master, with its own step predictor.
`timescale 1ns / 1ps

module i2c_master_register_access_tb;
	import i2cm_pkg::*;

	localparam int RANDOM_ITEMS = 700;
	localparam int FAULT_BUSY = 1;
	localparam int FAULT_STUCK = 2;
	localparam int FAULT_RS_BUSY = 4;
	localparam int FAULT_RS_STUCK = 8;

	class i2c_step_scoreboard;
		phase_t phase;
		logic [1:0] step;
		logic [3:0] bit_cnt;
		logic [7:0] shreg;
		logic [4:0] left;
		logic [7:0] dev;
		logic [7:0] regad;
		logic rd;
		logic [15:0] wdata;
		logic scl;
		logic sda;
		logic err_start;
		logic err_nack;
		result_t expected_steps[$];
		int mismatches;
		int n_checked;
		int n_done;
		int n_bytes;
		int n_requests;

		function new();
			phase = PH_IDLE;
			step = '0;
			bit_cnt = '0;
			shreg = '0;
			left = '0;
			dev = '0;
			regad = '0;
			rd = 1'b0;
			wdata = '0;
			scl = 1'b1;
			sda = 1'b1;
			err_start = 1'b0;
			err_nack = 1'b0;
			mismatches = 0;
			n_checked = 0;
			n_done = 0;
			n_bytes = 0;
			n_requests = 0;
		endfunction

		function void enter_phase(phase_t p, logic [7:0] load);
			phase = p;
			step = '0;
			bit_cnt = '0;
			shreg = load;
		endfunction

		function void next_data_byte();
			if (left > 0) begin
				left--;
				enter_phase(PH_DATA, (left == 5'd1) ? wdata[15:8] : wdata[7:0]);
			end else begin
				enter_phase(PH_STOP, 8'h00);
			end
		endfunction

		function void end_segment();
			case (phase)
			PH_START: enter_phase(PH_ADDRW, dev);
			PH_ADDRW: enter_phase(PH_ACK1, 8'h00);
			PH_ACK1: enter_phase(PH_REG, regad);
			PH_REG: enter_phase(PH_ACK2, 8'h00);
			PH_ACK2: begin
				if (rd)
					enter_phase(PH_RSTART, 8'h00);
				else
					next_data_byte();
			end
			PH_DATA: enter_phase(PH_ACK3, 8'h00);
			PH_ACK3: next_data_byte();
			PH_RSTART: enter_phase(PH_ADDRR, dev + 8'd1);
			PH_ADDRR: enter_phase(PH_ACK4, 8'h00);
			PH_ACK4: enter_phase(PH_RECV, 8'h00);
			PH_RECV: enter_phase(PH_MACK, 8'h00);
			PH_MACK: begin
				if (left > 1) begin
					left--;
					enter_phase(PH_RECV, 8'h00);
				end else begin
					left = '0;
					enter_phase(PH_STOP, 8'h00);
				end
			end
			default: enter_phase(PH_IDLE, 8'h00);
			endcase
		endfunction

		function result_t advance(item_t it);
			result_t r;
			logic [4:0] cnt;
			r = '0;
			if (it.kind) begin
				if (phase == PH_IDLE) begin
					dev = it.dev_addr;
					regad = it.reg_addr;
					rd = it.is_read;
					wdata = it.write_data;
					cnt = it.byte_count;
					if (rd) begin
						if (cnt == 0)
							cnt = 5'd1;
						if (cnt > MAX_READ_BYTES)
							cnt = 5'(MAX_READ_BYTES);
					end else if (cnt > MAX_WRITE_BYTES) begin
						cnt = MAX_WRITE_BYTES;
					end
					left = cnt;
					err_start = 1'b0;
					err_nack = 1'b0;
					enter_phase(PH_START, 8'h00);
				end
			end else begin
				case (phase)
				PH_START, PH_RSTART: begin
					if (step == 0) begin
						sda = 1'b1;
						scl = 1'b1;
						if (!it.sda_sample) begin
							err_start = 1'b1;
							end_segment();
						end else begin
							step = 2'd1;
						end
					end else if (step == 1) begin
						sda = 1'b0;
						if (it.sda_sample) begin
							err_start = 1'b1;
							end_segment();
						end else begin
							step = 2'd2;
						end
					end else begin
						sda = 1'b0;
						end_segment();
					end
				end
				PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
					if (bit_cnt >= 8) begin
						scl = 1'b0;
						end_segment();
					end else if (step == 0) begin
						scl = 1'b0;
						step = 2'd1;
					end else if (step == 1) begin
						sda = shreg[7];
						shreg = {shreg[6:0], 1'b0};
						step = 2'd2;
					end else begin
						scl = 1'b1;
						bit_cnt++;
						step = 2'd0;
					end
				end
				PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
					if (step == 0) begin
						scl = 1'b0;
						step = 2'd1;
					end else if (step == 1) begin
						sda = 1'b1;
						step = 2'd2;
					end else if (step == 2) begin
						scl = 1'b1;
						if (it.sda_sample)
							err_nack = 1'b1;
						step = 2'd3;
					end else begin
						scl = 1'b0;
						end_segment();
					end
				end
				PH_RECV: begin
					if (step == 0) begin
						sda = 1'b1;
						step = 2'd1;
					end else if (step == 1) begin
						scl = 1'b0;
						step = 2'd2;
					end else if (step == 2) begin
						scl = 1'b1;
						shreg = {shreg[6:0], it.sda_sample};
						bit_cnt++;
						step = (bit_cnt >= 8) ? 2'd3 : 2'd1;
					end else begin
						scl = 1'b0;
						r.read_valid = 1'b1;
						r.read_byte = shreg;
						r.last_byte = (left <= 1);
						end_segment();
					end
				end
				PH_MACK: begin
					if (step == 0) begin
						scl = 1'b0;
						step = 2'd1;
					end else if (step == 1) begin
						sda = (left > 1) ? 1'b0 : 1'b1;
						step = 2'd2;
					end else if (step == 2) begin
						scl = 1'b1;
						step = 2'd3;
					end else begin
						scl = 1'b0;
						end_segment();
					end
				end
				PH_STOP: begin
					if (step == 0) begin
						scl = 1'b0;
						step = 2'd1;
					end else if (step == 1) begin
						sda = 1'b0;
						step = 2'd2;
					end else if (step == 2) begin
						scl = 1'b1;
						step = 2'd3;
					end else begin
						sda = 1'b1;
						r.done_res = 1'b1;
						enter_phase(PH_IDLE, 8'h00);
					end
				end
				default: ;
				endcase
			end
			r.scl_level = scl;
			r.sda_release = sda;
			r.busy_res = (phase != PH_IDLE) || r.done_res;
			r.start_error = err_start;
			r.nack_error = err_nack;
			return r;
		endfunction

		function void note(item_t it);
			if (it.kind && phase == PH_IDLE)
				n_requests++;
			expected_steps.push_back(advance(it));
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] mismatch at result %0d: %s", $time, n_checked, msg);
		endtask

		task cmp(string name, logic [7:0] got, logic [7:0] exp);
			if (got !== exp)
				report($sformatf("%s got %h expected %h", name, got, exp));
		endtask

		task check(result_t got);
			result_t exp;
			if (expected_steps.size() == 0) begin
				report($sformatf("result %h arrived with nothing expected", got));
				return;
			end
			exp = expected_steps.pop_front();
			cmp("scl_level", 8'(got.scl_level), 8'(exp.scl_level));
			cmp("sda_release", 8'(got.sda_release), 8'(exp.sda_release));
			cmp("busy_res", 8'(got.busy_res), 8'(exp.busy_res));
			cmp("read_valid", 8'(got.read_valid), 8'(exp.read_valid));
			cmp("read_byte", got.read_byte, exp.read_byte);
			cmp("last_byte", 8'(got.last_byte), 8'(exp.last_byte));
			cmp("start_error", 8'(got.start_error), 8'(exp.start_error));
			cmp("nack_error", 8'(got.nack_error), 8'(exp.nack_error));
			cmp("done_res", 8'(got.done_res), 8'(exp.done_res));
			n_checked++;
			if (exp.done_res)
				n_done++;
			if (exp.read_valid)
				n_bytes++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	i2c_step_scoreboard bus_sb = new();
	i2c_step_scoreboard planner = new();
	int n_offered = 0;
	int burst_left = 0;

	i2c_master_register_access u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			bus_sb.check(result);
	end

	initial begin : receiver
		int cyc;
		int mode;
		int mode_left;
		int hold_left;
		cyc = 0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 1500 == 400)
				hold_left = $urandom_range(60, 100);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(10, 60);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				case (mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 2) == 0);
				2: result_stall <= (cyc % 4 == 0);
				default: result_stall <= ($urandom_range(0, 2) != 0);
				endcase
			end
		end
	end

	function automatic item_t random_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t make_tick(logic sample);
		item_t it;
		it = random_item();
		it.kind = 1'b0;
		it.sda_sample = sample;
		return it;
	endfunction

	function automatic item_t make_req(logic [7:0] dev, logic [7:0] regad, logic rd,
			logic [4:0] cnt, logic [15:0] data);
		item_t it;
		it = random_item();
		it.kind = 1'b1;
		it.dev_addr = dev;
		it.reg_addr = regad;
		it.is_read = rd;
		it.byte_count = cnt;
		it.write_data = data;
		return it;
	endfunction

	// Plays the slave side: a clean bus at START, ACKs unless told otherwise,
	// and random bits everywhere the master does not look.
	function automatic logic pick_sample(int fault, int nack_pct);
		logic again;
		again = (planner.phase == PH_RSTART);
		case (planner.phase)
		PH_START, PH_RSTART: begin
			if (planner.step == 0)
				return (fault & (again ? FAULT_RS_BUSY : FAULT_BUSY)) == 0;
			if (planner.step == 1)
				return (fault & (again ? FAULT_RS_STUCK : FAULT_STUCK)) != 0;
		end
		PH_ACK1, PH_ACK2, PH_ACK3, PH_ACK4: begin
			if (planner.step == 2)
				return $urandom_range(0, 99) < nack_pct;
		end
		default: ;
		endcase
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic push_item(item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		bus_sb.note(it);
	endtask

	task automatic offer(item_t it);
		if (!(it.kind && planner.phase != PH_IDLE))
			n_offered++;
		void'(planner.advance(it));
		push_item(it);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(posedge clk); while (bus_sb.expected_steps.size() != 0);
	endtask

	task automatic run_transaction(item_t req, int fault, int nack_pct, int noise_pct);
		offer(req);
		while (planner.phase != PH_IDLE) begin
			if ($urandom_range(0, 99) < noise_pct)
				offer(make_req(8'($urandom), 8'($urandom), 1'($urandom), 5'($urandom),
					16'($urandom)));
			offer(make_tick(pick_sample(fault, nack_pct)));
		end
	endtask

	initial begin : stimulus
		int start_count;
		int fault;
		int nack_pct;
		logic [4:0] cnt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(make_tick(1'b0));
		offer(make_tick(1'b1));
		run_transaction(make_req(8'h00, 8'h00, 1'b0, 5'd0, 16'h0000), 0, 0, 0);
		run_transaction(make_req(8'hfe, 8'hff, 1'b0, 5'd1, 16'ha55a), 0, 0, 0);
		run_transaction(make_req(8'h42, 8'h10, 1'b0, 5'd2, 16'hffff), 0, 0, 0);
		run_transaction(make_req(8'h42, 8'h11, 1'b0, 5'd31, 16'h1234), 0, 0, 0);
		wait_drained();
		run_transaction(make_req(8'hff, 8'h3c, 1'b1, 5'd0, 16'h0000), 0, 0, 0);
		run_transaction(make_req(8'hd0, 8'h75, 1'b1, 5'd16, 16'hffff), 0, 0, 20);
		run_transaction(make_req(8'h10, 8'h00, 1'b1, 5'd31, 16'h8001), 0, 0, 0);
		run_transaction(make_req(8'h50, 8'h20, 1'b0, 5'd2, 16'h00ff), FAULT_BUSY, 0, 0);
		run_transaction(make_req(8'h50, 8'h21, 1'b1, 5'd2, 16'h0000),
			FAULT_STUCK | FAULT_RS_STUCK, 0, 0);
		run_transaction(make_req(8'h50, 8'h22, 1'b1, 5'd1, 16'h0000), FAULT_RS_BUSY, 100, 0);
		run_transaction(make_req(8'h50, 8'h23, 1'b0, 5'd2, 16'h5a5a), 0, 100, 0);
		wait_drained();

		start_count = n_offered;
		while (n_offered - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				wait_drained();
			repeat ($urandom_range(0, 2)) offer(make_tick(1'($urandom_range(0, 1))));
			case ($urandom_range(0, 9))
			7, 8: cnt = 5'($urandom_range(0, 16));
			9: cnt = 5'($urandom_range(0, 31));
			default: cnt = 5'($urandom_range(0, 3));
			endcase
			fault = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 15) : 0;
			case ($urandom_range(0, 9))
			7, 8: nack_pct = 10;
			9: nack_pct = 60;
			default: nack_pct = 0;
			endcase
			run_transaction(make_req(8'($urandom), 8'($urandom), 1'($urandom), cnt,
				16'($urandom)), fault, nack_pct, 3);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d items and %0d requests: %0d transfers completed, %0d bytes read.",
			n_offered, bus_sb.n_requests, bus_sb.n_done, bus_sb.n_bytes);
		$display("Checked %0d results, %0d mismatches.", bus_sb.n_checked, bus_sb.mismatches);
		if (bus_sb.mismatches == 0 && bus_sb.expected_steps.size() == 0)
			$display("i2c_master_register_access regression: pass");
		else
			$display("i2c_master_register_access regression: fail");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Timed out with %0d results outstanding.", bus_sb.expected_steps.size());
		$display("i2c_master_register_access regression: fail");
		$finish;
	end

endmodule
